### src/rlvd_pkg.sv
// shared types, constants and helpers for the run-list cluster decoder
// no dependencies; used by every module of the block
package rlvd_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned ClusterW    = 48;
  localparam int unsigned RunLenW     = 64;
  localparam int unsigned NibbleW     = 4;
  localparam int unsigned PosW        = 3;
  localparam int unsigned StatusW     = 2;

  // largest byte count a header nibble may give
  localparam logic [NibbleW-1:0] MaxFieldBytes = 4'd8;

  // decode phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_OFFSET = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] ST_FOUND  = 2'd0;
  localparam logic [StatusW-1:0] ST_END    = 2'd1;
  localparam logic [StatusW-1:0] ST_BAD    = 2'd2;
  localparam logic [StatusW-1:0] ST_SPARSE = 2'd3;

  // one input beat
  typedef struct packed {
    logic [ByteW-1:0]    run_byte;
    logic                list_start;
    logic [ClusterW-1:0] target_vcn;
  } item_t;

  // one result beat
  typedef struct packed {
    logic [ClusterW-1:0] lcn;
    logic [StatusW-1:0]  status;
  } result_t;

  // sign-extend an n-byte little-endian delta to the cluster width
  function automatic logic [ClusterW-1:0] sext_delta(input logic [ClusterW-1:0] d,
                                                     input logic [NibbleW-1:0]  n);
    logic [ClusterW-1:0] r;
    begin
      r = d;
      case (n)
        4'd1: r = {{40{d[7]}},  d[7:0]};
        4'd2: r = {{32{d[15]}}, d[15:0]};
        4'd3: r = {{24{d[23]}}, d[23:0]};
        4'd4: r = {{16{d[31]}}, d[31:0]};
        4'd5: r = {{8{d[39]}},  d[39:0]};
        default: r = d;
      endcase
      return r;
    end
  endfunction

endpackage

### src/rlvd_in_stage.sv
// input register: holds one accepted byte beat until the decoder takes it
// depends on rlvd_pkg
module rlvd_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  rlvd_pkg::item_t  item_i,
  output logic             valid_o,
  input  logic             take_i,
  output rlvd_pkg::item_t  item_o
);

  logic            valid_q, valid_d;
  rlvd_pkg::item_t item_q;

  // free when empty or when the held beat leaves this cycle
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### src/rlvd_decode.sv
// run-list walker: header, length and offset parsing plus the hit test
// depends on rlvd_pkg
module rlvd_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rlvd_pkg::item_t    item_i,
  input  logic               out_free_i,
  output logic               take_o,
  output logic               emit_o,
  output rlvd_pkg::result_t  result_o
);

  logic [1:0]                          phase_q, phase_d;
  logic                                resolved_q, resolved_d;
  logic [rlvd_pkg::NibbleW-1:0]        len_left_q, len_left_d;
  logic [rlvd_pkg::NibbleW-1:0]        off_left_q, off_left_d;
  logic [rlvd_pkg::NibbleW-1:0]        off_cnt_q, off_cnt_d;
  logic [rlvd_pkg::PosW-1:0]           pos_q, pos_d;
  logic [rlvd_pkg::RunLenW-1:0]        run_len_q, run_len_d;
  logic [rlvd_pkg::ClusterW-1:0]       delta_q, delta_d;
  // target minus the current run's virtual start; never negative
  logic [rlvd_pkg::ClusterW-1:0]       vdiff_q, vdiff_d;
  logic [rlvd_pkg::ClusterW-1:0]       lcn_q, lcn_d;

  // state as seen by this beat once a list start is applied
  logic [1:0]                          ph_eff;
  logic                                res_eff;
  logic [rlvd_pkg::ClusterW-1:0]       vdiff_eff;
  logic [rlvd_pkg::ClusterW-1:0]       lcn_eff;

  logic [rlvd_pkg::ByteW-1:0]          b;
  logic [rlvd_pkg::NibbleW-1:0]        ln, on;
  logic [rlvd_pkg::RunLenW-1:0]        len_new;
  logic [rlvd_pkg::ClusterW-1:0]       delta_new;
  logic [rlvd_pkg::ClusterW-1:0]       lcn_new;
  logic [rlvd_pkg::NibbleW-1:0]        left_dec;
  logic                                hit;
  logic                                emit;
  rlvd_pkg::result_t                   res;

  assign take_o = valid_i && out_free_i;
  assign b      = item_i.run_byte;
  assign ln     = b[3:0];
  assign on     = b[7:4];

  // list start restarts the walk and this byte is the first header
  always_comb begin
    if (item_i.list_start) begin
      ph_eff    = rlvd_pkg::PH_HEADER;
      res_eff   = 1'b0;
      vdiff_eff = item_i.target_vcn;
      lcn_eff   = '0;
    end else begin
      ph_eff    = phase_q;
      res_eff   = resolved_q;
      vdiff_eff = vdiff_q;
      lcn_eff   = lcn_q;
    end
  end

  // byte insertion into the little-endian accumulators
  assign len_new   = run_len_q | (rlvd_pkg::RunLenW'(b) << {pos_q, 3'b000});
  assign delta_new = delta_q | (rlvd_pkg::ClusterW'(b) << {pos_q, 3'b000});
  assign lcn_new   = lcn_eff + rlvd_pkg::sext_delta(delta_new, off_cnt_q);

  // hit test against the finished run length
  always_comb begin
    if (ph_eff == rlvd_pkg::PH_LENGTH) begin
      hit = {16'd0, vdiff_eff} < len_new;
    end else begin
      hit = {16'd0, vdiff_eff} < run_len_q;
    end
  end

  // next state and result for one byte
  always_comb begin
    phase_d    = ph_eff;
    resolved_d = res_eff;
    len_left_d = len_left_q;
    off_left_d = off_left_q;
    off_cnt_d  = off_cnt_q;
    pos_d      = pos_q;
    run_len_d  = run_len_q;
    delta_d    = delta_q;
    vdiff_d    = vdiff_eff;
    lcn_d      = lcn_eff;
    emit       = 1'b0;
    res.lcn    = '0;
    res.status = rlvd_pkg::ST_END;
    left_dec   = '0;
    if (!res_eff) begin
      case (ph_eff)
        rlvd_pkg::PH_HEADER: begin
          if (b == '0) begin
            emit       = 1'b1;
            res.status = rlvd_pkg::ST_END;
          end else if (ln == '0 || ln > rlvd_pkg::MaxFieldBytes
                       || on > rlvd_pkg::MaxFieldBytes) begin
            emit       = 1'b1;
            res.status = rlvd_pkg::ST_BAD;
          end else begin
            len_left_d = ln;
            off_left_d = on;
            off_cnt_d  = on;
            pos_d      = '0;
            run_len_d  = '0;
            delta_d    = '0;
            phase_d    = rlvd_pkg::PH_LENGTH;
          end
        end
        rlvd_pkg::PH_LENGTH: begin
          left_dec   = len_left_q - 4'd1;
          run_len_d  = len_new;
          pos_d      = pos_q + 3'd1;
          len_left_d = left_dec;
          if (left_dec == '0) begin
            pos_d = '0;
            if (off_cnt_q == '0) begin
              // sparse run: answer or skip it
              if (hit) begin
                emit       = 1'b1;
                res.status = rlvd_pkg::ST_SPARSE;
              end else begin
                vdiff_d = vdiff_eff - len_new[rlvd_pkg::ClusterW-1:0];
                phase_d = rlvd_pkg::PH_HEADER;
              end
            end else begin
              phase_d = rlvd_pkg::PH_OFFSET;
            end
          end
        end
        rlvd_pkg::PH_OFFSET: begin
          left_dec   = off_left_q - 4'd1;
          delta_d    = delta_new;
          pos_d      = pos_q + 3'd1;
          off_left_d = left_dec;
          if (left_dec == '0) begin
            pos_d = '0;
            lcn_d = lcn_new;
            if (hit) begin
              emit       = 1'b1;
              res.status = rlvd_pkg::ST_FOUND;
              res.lcn    = lcn_new + vdiff_eff;
            end else begin
              vdiff_d = vdiff_eff - run_len_q[rlvd_pkg::ClusterW-1:0];
              phase_d = rlvd_pkg::PH_HEADER;
            end
          end
        end
        default: begin
          phase_d = rlvd_pkg::PH_HEADER;
        end
      endcase
      if (emit) begin
        resolved_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rlvd_pkg::PH_HEADER;
      resolved_q <= 1'b1;
      len_left_q <= '0;
      off_left_q <= '0;
      off_cnt_q  <= '0;
      pos_q      <= '0;
      run_len_q  <= '0;
      delta_q    <= '0;
      vdiff_q    <= '0;
      lcn_q      <= '0;
    end else if (take_o) begin
      phase_q    <= phase_d;
      resolved_q <= resolved_d;
      len_left_q <= len_left_d;
      off_left_q <= off_left_d;
      off_cnt_q  <= off_cnt_d;
      pos_q      <= pos_d;
      run_len_q  <= run_len_d;
      delta_q    <= delta_d;
      vdiff_q    <= vdiff_d;
      lcn_q      <= lcn_d;
    end
  end

  assign emit_o   = take_o && emit;
  assign result_o = res;

endmodule

### src/rlvd_out_stage.sv
// result register: holds one result beat until the consumer takes it
// depends on rlvd_pkg
module rlvd_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  rlvd_pkg::result_t  result_i,
  output logic               free_o,
  output logic               valid_o,
  input  logic               ready_i,
  output rlvd_pkg::result_t  result_o
);

  logic              valid_q, valid_d;
  rlvd_pkg::result_t result_q;

  // free when empty or when the held beat is taken this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

### src/runlist_vcn_to_lcn_decoder_top.sv
// top level of the run-list cluster decoder: input register, walker, result register
// depends on rlvd_pkg, rlvd_in_stage, rlvd_decode, rlvd_out_stage

// The block walks an extent run list one byte per beat and translates one virtual
// cluster to its physical cluster. A beat with list_start high begins a new list,
// samples target_vcn and is itself the first run header. One byte is taken every
// cycle while the result register is empty or being drained; a byte waits in the
// input register while an earlier result is stalled. A result is offered once the byte
// that causes it has passed the input register and then the whole per-byte decode into
// the result register; a stalled earlier result can hold that byte in the input register.
// Each list gives at most one result (found, end of list, malformed header or sparse
// run); bytes after it are dropped until the next list start, as are bytes before the
// first start.
module runlist_vcn_to_lcn_decoder_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rlvd_pkg::ByteW-1:0]          run_byte_i,
  input  logic                                list_start_i,
  input  logic [rlvd_pkg::ClusterW-1:0]       target_vcn_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rlvd_pkg::ClusterW-1:0]       lcn_o,
  output logic [rlvd_pkg::StatusW-1:0]        status_o
);

  rlvd_pkg::item_t   in_item;
  rlvd_pkg::item_t   held_item;
  rlvd_pkg::result_t dec_result;
  rlvd_pkg::result_t out_result;
  logic              held_valid;
  logic              take;
  logic              emit;
  logic              out_free;

  assign in_item.run_byte   = run_byte_i;
  assign in_item.list_start = list_start_i;
  assign in_item.target_vcn = target_vcn_i;

  // input register
  rlvd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (take),
    .item_o  (held_item)
  );

  // per-byte decode
  rlvd_decode u_dec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (held_valid),
    .item_i     (held_item),
    .out_free_i (out_free),
    .take_o     (take),
    .emit_o     (emit),
    .result_o   (dec_result)
  );

  // result register
  rlvd_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (emit),
    .result_i (dec_result),
    .free_o   (out_free),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (out_result)
  );

  assign lcn_o    = out_result.lcn;
  assign status_o = out_result.status;

endmodule

### src/rlvd_checker.sv
// port-level checks for the run-list cluster decoder, bound to the top level
// depends on rlvd_pkg and runlist_vcn_to_lcn_decoder_top
module rlvd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [rlvd_pkg::ClusterW-1:0]       lcn_o,
  input logic [rlvd_pkg::StatusW-1:0]        status_o
);

  // a waiting result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a waiting result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(lcn_o) && $stable(status_o))
    else $error("result payload changed while stalled");

  // only a found result carries a cluster
  a_lcn_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != rlvd_pkg::ST_FOUND |-> lcn_o == '0)
    else $error("cluster field set on a miss");

  // with the result register empty nothing blocks the input side
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

bind runlist_vcn_to_lcn_decoder_top rlvd_checker u_rlvd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .lcn_o       (lcn_o),
  .status_o    (status_o)
);

### sim/tb_runlist_vcn_to_lcn_decoder_top.sv
// self-checking testbench for runlist_vcn_to_lcn_decoder_top: directed table, then random lists
// depends on rlvd_pkg and the block's RTL; checks results by typed rows or its run-list walker
module tb_runlist_vcn_to_lcn_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRows    = 23;
  localparam int unsigned RandBeats  = 1950;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned IdlePct    = 23;

  // one row of the directed table; a typed row carries its own expected result
  typedef struct packed {
    logic [rlvd_pkg::ByteW-1:0]    run_byte;
    logic                          list_start;
    logic [rlvd_pkg::ClusterW-1:0] target_vcn;
    logic                          typed;
    logic [rlvd_pkg::ClusterW-1:0] lcn;
    logic [rlvd_pkg::StatusW-1:0]  status;
  } row_t;

  logic                          clk_i;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_ready_o;
  logic [rlvd_pkg::ByteW-1:0]    run_byte_i   = '0;
  logic                          list_start_i = 1'b0;
  logic [rlvd_pkg::ClusterW-1:0] target_vcn_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i  = 1'b0;
  logic [rlvd_pkg::ClusterW-1:0] lcn_o;
  logic [rlvd_pkg::StatusW-1:0]  status_o;

  runlist_vcn_to_lcn_decoder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .run_byte_i   (run_byte_i),
    .list_start_i (list_start_i),
    .target_vcn_i (target_vcn_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .lcn_o        (lcn_o),
    .status_o     (status_o)
  );

  // walker state, mirrors the block
  logic [1:0]                    walk_phase;
  logic [rlvd_pkg::NibbleW-1:0]  len_left;
  logic [rlvd_pkg::NibbleW-1:0]  off_left;
  logic [rlvd_pkg::NibbleW-1:0]  off_count;
  logic [rlvd_pkg::PosW-1:0]     byte_pos;
  logic [rlvd_pkg::RunLenW-1:0]  run_len;
  logic [rlvd_pkg::RunLenW-1:0]  delta;
  logic [rlvd_pkg::ClusterW-1:0] run_vstart;
  logic [rlvd_pkg::RunLenW-1:0]  phys_start;
  logic [rlvd_pkg::ClusterW-1:0] wanted_vcn;
  bit                            list_done;

  rlvd_pkg::result_t pending_results[$];
  rlvd_pkg::result_t head_result;
  row_t              dir_rows [NumRows];

  int unsigned cycles;
  int unsigned fails;
  int unsigned beats_sent;
  int unsigned walked_beats;
  int unsigned lists_sent;
  int unsigned status_seen [4];
  bit          steady;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run fully read: answer if the wanted cluster is inside, else step to the next run
  function automatic bit close_run(input bit sparse,
                                   output logic [rlvd_pkg::ClusterW-1:0] lcn,
                                   output logic [rlvd_pkg::StatusW-1:0] status);
    logic [rlvd_pkg::ClusterW-1:0] rel;
    rel    = wanted_vcn - run_vstart;
    lcn    = '0;
    status = rlvd_pkg::ST_FOUND;
    if (wanted_vcn >= run_vstart && rlvd_pkg::RunLenW'(rel) < run_len) begin
      list_done = 1'b1;
      if (sparse) begin
        status = rlvd_pkg::ST_SPARSE;
      end else begin
        lcn = rlvd_pkg::ClusterW'(phys_start + rlvd_pkg::RunLenW'(rel));
      end
      return 1'b1;
    end
    run_vstart = rlvd_pkg::ClusterW'(rlvd_pkg::RunLenW'(run_vstart) + run_len);
    walk_phase = rlvd_pkg::PH_HEADER;
    return 1'b0;
  endfunction

  // feed one accepted beat to the walker; returns 1 when it gives a result
  function automatic bit walk_byte(input logic [rlvd_pkg::ByteW-1:0] b, input logic st,
                                   input logic [rlvd_pkg::ClusterW-1:0] tgt,
                                   output bit engaged,
                                   output logic [rlvd_pkg::ClusterW-1:0] lcn,
                                   output logic [rlvd_pkg::StatusW-1:0] status);
    logic [rlvd_pkg::NibbleW-1:0] len_nib;
    logic [rlvd_pkg::NibbleW-1:0] off_nib;
    logic [rlvd_pkg::RunLenW-1:0] ext;
    int                           nbits;
    engaged = 1'b0;
    lcn     = '0;
    status  = rlvd_pkg::ST_FOUND;
    len_nib = b[3:0];
    off_nib = b[7:4];
    if (st) begin
      wanted_vcn = tgt;
      run_vstart = '0;
      phys_start = '0;
      walk_phase = rlvd_pkg::PH_HEADER;
      list_done  = 1'b0;
    end
    if (list_done) return 1'b0;
    engaged = 1'b1;
    case (walk_phase)
      rlvd_pkg::PH_HEADER: begin
        if (b == '0) begin
          status    = rlvd_pkg::ST_END;
          list_done = 1'b1;
          return 1'b1;
        end
        if (len_nib == '0 || len_nib > rlvd_pkg::MaxFieldBytes
            || off_nib > rlvd_pkg::MaxFieldBytes) begin
          status    = rlvd_pkg::ST_BAD;
          list_done = 1'b1;
          return 1'b1;
        end
        len_left   = len_nib;
        off_left   = off_nib;
        off_count  = off_nib;
        byte_pos   = '0;
        run_len    = '0;
        delta      = '0;
        walk_phase = rlvd_pkg::PH_LENGTH;
        return 1'b0;
      end
      rlvd_pkg::PH_LENGTH: begin
        run_len  = run_len | (rlvd_pkg::RunLenW'(b) << (8 * byte_pos));
        byte_pos = byte_pos + 3'd1;
        len_left = len_left - 4'd1;
        if (len_left != '0) return 1'b0;
        byte_pos = '0;
        if (off_count == '0) return close_run(1'b1, lcn, status);
        walk_phase = rlvd_pkg::PH_OFFSET;
        return 1'b0;
      end
      default: begin
        delta    = delta | (rlvd_pkg::RunLenW'(b) << (8 * byte_pos));
        byte_pos = byte_pos + 3'd1;
        if (off_left != '0) off_left = off_left - 4'd1;
        if (off_left != '0) return 1'b0;
        byte_pos = '0;
        // sign-extend short deltas, a full eight-byte delta is taken as is
        ext   = delta;
        nbits = 8 * int'(off_count);
        if (nbits < 64 && delta[nbits-1]) ext = ext | ({rlvd_pkg::RunLenW{1'b1}} << nbits);
        phys_start = (phys_start + ext) & rlvd_pkg::RunLenW'({rlvd_pkg::ClusterW{1'b1}});
        return close_run(1'b0, lcn, status);
      end
    endcase
  endfunction

  // drive one beat, wait for acceptance, then record what it should give
  task automatic send_beat(input logic [rlvd_pkg::ByteW-1:0] b, input logic st,
                           input logic [rlvd_pkg::ClusterW-1:0] tgt, input logic typed,
                           input logic [rlvd_pkg::ClusterW-1:0] t_lcn,
                           input logic [rlvd_pkg::StatusW-1:0] t_status);
    bit                            hit;
    bit                            engaged;
    logic [rlvd_pkg::ClusterW-1:0] p_lcn;
    logic [rlvd_pkg::StatusW-1:0]  p_status;
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    run_byte_i   <= b;
    list_start_i <= st;
    target_vcn_i <= tgt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    hit = walk_byte(b, st, tgt, engaged, p_lcn, p_status);
    if (engaged) walked_beats++;
    if (typed) pending_results.push_back({t_lcn, t_status});
    else if (hit) pending_results.push_back({p_lcn, p_status});
    beats_sent++;
    @(negedge clk_i);
  endtask

  // junk for target_vcn on beats that do not start a list
  function automatic logic [rlvd_pkg::ClusterW-1:0] junk_vcn();
    return rlvd_pkg::ClusterW'({$urandom(), $urandom()});
  endfunction

  // one random run list: mostly well formed, some bad headers and missing terminators
  task automatic send_list();
    logic [rlvd_pkg::ClusterW-1:0] tgt;
    logic [rlvd_pkg::ByteW-1:0]    hdr;
    int unsigned                   runs;
    int unsigned                   pick;
    int unsigned                   len_n;
    int unsigned                   off_n;
    bit                            first;
    pick = $urandom_range(0, 9);
    if (pick < 6) tgt = rlvd_pkg::ClusterW'($urandom_range(0, 800));
    else if (pick < 9) tgt = junk_vcn();
    else tgt = '0;
    runs  = $urandom_range(1, 5);
    first = 1'b1;
    lists_sent++;
    for (int unsigned r = 0; r < runs; r++) begin
      pick = $urandom_range(0, 19);
      len_n = 0;
      off_n = 0;
      if (pick == 0) begin
        case ($urandom_range(0, 2))
          0: hdr = {4'($urandom_range(0, 15)), 4'h0};
          1: hdr = {4'($urandom_range(9, 15)), 4'($urandom_range(1, 8))};
          default: hdr = {4'($urandom_range(0, 8)), 4'($urandom_range(9, 15))};
        endcase
      end else begin
        len_n = (pick < 14) ? $urandom_range(1, 2) : $urandom_range(1, 8);
        if (pick % 5 == 0) off_n = 0;
        else if ($urandom_range(0, 3) == 0) off_n = $urandom_range(1, 8);
        else off_n = $urandom_range(1, 2);
        hdr = {4'(off_n), 4'(len_n)};
      end
      send_beat(hdr, first, first ? tgt : junk_vcn(), 1'b0, '0, rlvd_pkg::ST_FOUND);
      first = 1'b0;
      for (int unsigned i = 0; i < len_n + off_n; i++) begin
        send_beat(8'($urandom()), 1'b0, junk_vcn(), 1'b0, '0, rlvd_pkg::ST_FOUND);
      end
    end
    // terminator, a stray byte, or nothing at all
    pick = $urandom_range(0, 19);
    if (pick < 15) begin
      send_beat('0, 1'b0, junk_vcn(), 1'b0, '0, rlvd_pkg::ST_FOUND);
    end else if (pick < 18) begin
      send_beat(8'($urandom()), 1'b0, junk_vcn(), 1'b0, '0, rlvd_pkg::ST_FOUND);
    end
  endtask

  // result side stalls at random, except during the steady stretch
  always @(negedge clk_i) begin
    out_ready_i <= steady ? 1'b1 : ($urandom_range(0, 99) >= IdlePct);
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: lcn %h status %0d", lcn_o, status_o);
        fails++;
      end else begin
        head_result = pending_results.pop_front();
        status_seen[head_result.status]++;
        if (lcn_o !== head_result.lcn) begin
          $error("lcn: expected %h, got %h", head_result.lcn, lcn_o);
          fails++;
        end
        if (status_o !== head_result.status) begin
          $error("status: expected %0d, got %0d", head_result.status, status_o);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("[runlist_vcn_to_lcn_decoder_top] ERROR");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    bit paused;
    // bytes before any start, terminator, ignored byte after a result
    dir_rows[0]  = {8'h21, 1'b0, 48'd0, 1'b0, 48'd0, rlvd_pkg::ST_FOUND};
    dir_rows[1]  = {8'h00, 1'b1, 48'd0, 1'b1, 48'd0, rlvd_pkg::ST_END};
    dir_rows[2]  = {8'h11, 1'b0, 48'd0, 1'b0, 48'd0, rlvd_pkg::ST_FOUND};
    // malformed headers: length nibble too big, length nibble zero, offset nibble too big
    dir_rows[3]  = {8'h09, 1'b1, 48'd5, 1'b1, 48'd0, rlvd_pkg::ST_BAD};
    dir_rows[4]  = {8'h90, 1'b1, 48'd5, 1'b1, 48'd0, rlvd_pkg::ST_BAD};
    dir_rows[5]  = {8'hF1, 1'b1, 48'd5, 1'b1, 48'd0, rlvd_pkg::ST_BAD};
    // sparse run holding the target
    dir_rows[6]  = {8'h01, 1'b1, 48'd3, 1'b0, 48'd0, rlvd_pkg::ST_FOUND};
    dir_rows[7]  = {8'h10, 1'b0, 48'd0, 1'b1, 48'd0, rlvd_pkg::ST_SPARSE};
    // plain hit in the first run
    dir_rows[8]  = {8'h11, 1'b1, 48'd2, 1'b0, 48'd0, rlvd_pkg::ST_FOUND};
    dir_rows[9]  = {8'h04, 1'b0, 48'd0, 1'b0, 48'd0, rlvd_pkg::ST_FOUND};
    dir_rows[10] = {8'h10, 1'b0, 48'd0, 1'b1, 48'h12, rlvd_pkg::ST_FOUND};
    // new start abandons a list in progress
    dir_rows[11] = {8'h11, 1'b1, 48'd1, 1'b0, 48'd0, rlvd_pkg::ST_FOUND};
    dir_rows[12] = {8'h00, 1'b1, 48'd0, 1'b1, 48'd0, rlvd_pkg::ST_END};
    // largest target, eight-byte length, negative delta, physical wrap
    dir_rows[13] = {8'h18, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b0, 48'd0, rlvd_pkg::ST_FOUND};
    for (int i = 14; i < 22; i++) begin
      dir_rows[i] = {8'hFF, 1'b0, 48'd0, 1'b0, 48'd0, rlvd_pkg::ST_FOUND};
    end
    dir_rows[22] = {8'h80, 1'b0, 48'd0, 1'b1, 48'hFFFF_FFFF_FF7F, rlvd_pkg::ST_FOUND};

    walk_phase = rlvd_pkg::PH_HEADER;
    len_left   = '0;
    off_left   = '0;
    off_count  = '0;
    byte_pos   = '0;
    run_len    = '0;
    delta      = '0;
    run_vstart = '0;
    phys_start = '0;
    wanted_vcn = '0;
    list_done  = 1'b1;
    paused     = 1'b0;
    steady     = 1'b0;

    // reset
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    for (int i = 0; i < NumRows; i++) begin
      send_beat(dir_rows[i].run_byte, dir_rows[i].list_start, dir_rows[i].target_vcn,
                dir_rows[i].typed, dir_rows[i].lcn, dir_rows[i].status);
    end

    // random lists with some noise beats
    walked_beats = 0;
    while (beats_sent < NumRows + RandBeats) begin
      steady = (beats_sent >= NumRows + 700 && beats_sent < NumRows + 1000);
      if (!paused && beats_sent >= NumRows + 400) begin
        // hold off until every outstanding result has drained
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (pending_results.size() != 0) @(negedge clk_i);
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 4)) begin
          send_beat(8'($urandom()), ($urandom_range(0, 4) == 0), junk_vcn(), 1'b0, '0,
                    rlvd_pkg::ST_FOUND);
        end
      end else begin
        send_list();
      end
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    // drain, then let the pipeline settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("sent %0d beats: the directed table and %0d random lists, %0d random beats decoded",
             beats_sent, lists_sent, walked_beats);
    $display("results: %0d found, %0d end of list, %0d malformed, %0d sparse",
             status_seen[rlvd_pkg::ST_FOUND], status_seen[rlvd_pkg::ST_END],
             status_seen[rlvd_pkg::ST_BAD], status_seen[rlvd_pkg::ST_SPARSE]);
    if (fails == 0) begin
      $display("[runlist_vcn_to_lcn_decoder_top] OK");
    end else begin
      $display("[runlist_vcn_to_lcn_decoder_top] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/rlvd_pkg.sv
src/rlvd_in_stage.sv
src/rlvd_decode.sv
src/rlvd_out_stage.sv
src/runlist_vcn_to_lcn_decoder_top.sv
src/rlvd_checker.sv
sim/tb_runlist_vcn_to_lcn_decoder_top.sv
